FILE: rtl/wash_cycle_sequencer_defines.svh
// Assertion macros shared by the wash-cycle sequencer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef WASH_CYCLE_SEQUENCER_DEFINES_SVH
`define WASH_CYCLE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define WCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wash_cycle_sequencer: assertion failed");

// Next-cycle implication, disabled while reset is held
`define WCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wash_cycle_sequencer: assertion failed");

`endif

FILE: rtl/wcs_pkg.sv
// Types, constants and helper functions of the wash-cycle sequencer.
// No dependencies; used by the configuration channel interface, the top level and the testbench.
package wcs_pkg;

  // Phase codes as seen on phase_code
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SET_WASH  = 3'd1,
    PH_SET_RINSE = 3'd2,
    PH_SET_SPIN  = 3'd3,
    PH_WASH      = 3'd4,
    PH_RINSE     = 3'd5,
    PH_SPIN      = 3'd6,
    PH_PAUSE     = 3'd7
  } phase_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_WASH_DUTY  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RINSE_DUTY = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_DUTY  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_STEP   = 8'd3;
  localparam int unsigned CFG_DATA_W = 8;

  // Register reset values
  localparam logic [7:0] WASH_DUTY_RST  = 8'd120;
  localparam logic [7:0] RINSE_DUTY_RST = 8'd180;
  localparam logic [7:0] SPIN_DUTY_RST  = 8'd255;
  localparam logic [3:0] SEC_STEP_RST   = 4'd10;

  // Timing constants
  localparam int unsigned RES_W = 13;            // holds 0..7999
  localparam logic [RES_W-1:0] WASH_PERIOD_LAST = 13'd7999;
  localparam logic [RES_W-1:0] WASH_FWD_END     = 13'd3000;
  localparam logic [RES_W-1:0] WASH_GAP1_END    = 13'd4000;
  localparam logic [RES_W-1:0] WASH_REV_END     = 13'd7000;
  localparam logic [31:0]      RINSE_FLIP       = 32'd2000;
  localparam logic [9:0]       MILLIS_TOP       = 10'd999;
  localparam logic [3:0]       SETTING_MAX      = 4'd9;
  localparam logic [7:0]       SECONDS_MAX      = 8'd99;

  // LED patterns
  localparam logic [7:0] LED_WASH      = 8'h01;
  localparam logic [7:0] LED_RINSE     = 8'h02;
  localparam logic [7:0] LED_SPIN      = 8'h04;
  localparam logic [7:0] LED_SET_WASH  = 8'h08;
  localparam logic [7:0] LED_SET_RINSE = 8'h10;
  localparam logic [7:0] LED_SET_SPIN  = 8'h20;
  localparam logic [7:0] LED_PAUSE     = 8'h80;
  localparam logic [7:0] LED_OFF       = 8'h00;

  // Phase length in seconds, saturated at 99
  function automatic logic [6:0] phase_seconds(input logic [3:0] setting,
                                               input logic [3:0] sec_step);
    logic [7:0] prod;
    prod = {4'd0, setting} * {4'd0, sec_step};
    return (prod > SECONDS_MAX) ? SECONDS_MAX[6:0] : prod[6:0];
  endfunction

  // Raise a setting by one, wrapping 9 back to 1
  function automatic logic [3:0] bump_setting(input logic [3:0] v);
    logic [4:0] inc;
    inc = {1'b0, v} + 5'd1;
    return (inc > {1'b0, SETTING_MAX}) ? 4'd1 : inc[3:0];
  endfunction

endpackage

FILE: rtl/wcs_in_if.sv
// Input channel of the wash-cycle sequencer: one control pass per beat.
// No dependencies.
interface wcs_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic mode_press;
  logic adjust_press;
  logic start_pause_press;
  logic cancel_press;

  modport source (output valid, tick, mode_press, adjust_press, start_pause_press,
                  cancel_press, input ready);
  modport sink (input valid, tick, mode_press, adjust_press, start_pause_press,
                cancel_press, output ready);
endinterface

FILE: rtl/wcs_out_if.sv
// Result channel of the wash-cycle sequencer: display and motor state per beat.
// No dependencies.
interface wcs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] phase_code;
  logic [7:0] motor_duty;
  logic       drive_forward;
  logic       drive_reverse;
  logic [7:0] led_pattern;
  logic [6:0] seconds_shown;
  logic [9:0] millis_shown;

  modport source (output valid, phase_code, motor_duty, drive_forward, drive_reverse,
                  led_pattern, seconds_shown, millis_shown, input ready);
  modport sink (input valid, phase_code, motor_duty, drive_forward, drive_reverse,
                led_pattern, seconds_shown, millis_shown, output ready);
endinterface

FILE: rtl/wcs_cfg_if.sv
// Configuration write channel of the wash-cycle sequencer.
// Depends on wcs_pkg for the index and data widths.
interface wcs_cfg_if
  import wcs_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/wash_cycle_sequencer.sv
// Wash-cycle sequencer. Takes one control pass per clock; its result appears in the
// output register on the next clock and stays there until taken. The whole pass
// (buttons, countdown, phase change, motor pattern) is one layer of next-state logic
// between the state registers and the result register, so the rate is one beat per
// clock whenever the result side keeps up. Configuration writes are always taken;
// an index beyond 3 is dropped. There is no clearing pass after reset.
// Depends on wcs_pkg, the three channel interfaces and wash_cycle_sequencer_defines.svh.
`include "wash_cycle_sequencer_defines.svh"

module wash_cycle_sequencer
  import wcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  wcs_in_if.sink    in_ch,
  wcs_out_if.source out_ch,
  wcs_cfg_if.sink   cfg_ch
);

  // Configuration registers
  logic [7:0] wash_duty_r, rinse_duty_r, spin_duty_r;
  logic [3:0] sec_step_r;

  // Sequencer state
  phase_t           phase_r, phase_nxt;
  phase_t           saved_phase_r, saved_phase_nxt;
  logic [3:0]       wash_set_r, wash_set_nxt;
  logic [3:0]       rinse_set_r, rinse_set_nxt;
  logic [3:0]       spin_set_r, spin_set_nxt;
  logic [6:0]       sec_left_r, sec_left_nxt;
  logic [9:0]       ms_left_r, ms_left_nxt;
  logic [31:0]      since_ref_r, since_ref_nxt;
  logic [RES_W-1:0] wash_pos_r, wash_pos_nxt;   // since_ref mod 8000
  logic             rinse_dir_r, rinse_dir_nxt;
  logic             fwd_r, fwd_nxt;
  logic             rev_r, rev_nxt;

  // Result register
  logic       out_valid_r;
  logic [7:0] duty_r, duty_nxt;
  logic [7:0] led_r, led_nxt;
  logic [6:0] secs_r, secs_nxt;
  logic [9:0] ms_r, ms_nxt;

  logic in_fire;
  logic cfg_fire;
  logic running;

  // Take a new beat whenever the result register is empty or being drained
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  // Next state and result for one control pass
  always_comb begin
    phase_nxt       = phase_r;
    saved_phase_nxt = saved_phase_r;
    wash_set_nxt    = wash_set_r;
    rinse_set_nxt   = rinse_set_r;
    spin_set_nxt    = spin_set_r;
    sec_left_nxt    = sec_left_r;
    ms_left_nxt     = ms_left_r;
    since_ref_nxt   = since_ref_r;
    wash_pos_nxt    = wash_pos_r;
    rinse_dir_nxt   = rinse_dir_r;
    fwd_nxt         = fwd_r;
    rev_nxt         = rev_r;
    duty_nxt        = 8'd0;
    led_nxt         = LED_OFF;
    running         = 1'b0;

    // Advance the reference count; the residue restarts when the count wraps
    if (in_ch.tick) begin
      since_ref_nxt = since_ref_r + 32'd1;
      wash_pos_nxt  = (wash_pos_r == WASH_PERIOD_LAST) ? '0 : wash_pos_r + 13'd1;
      if (since_ref_nxt == 32'd0) begin
        wash_pos_nxt = '0;
      end
    end

    // Mode button walks through the setting menu
    if (in_ch.mode_press) begin
      unique case (phase_nxt)
        PH_IDLE:      phase_nxt = PH_SET_WASH;
        PH_SET_WASH:  phase_nxt = PH_SET_RINSE;
        PH_SET_RINSE: phase_nxt = PH_SET_SPIN;
        PH_SET_SPIN:  phase_nxt = PH_IDLE;
        default:      phase_nxt = phase_nxt;
      endcase
    end

    // Adjust raises the setting on display
    if (in_ch.adjust_press) begin
      unique case (phase_nxt)
        PH_SET_WASH:  wash_set_nxt  = bump_setting(wash_set_r);
        PH_SET_RINSE: rinse_set_nxt = bump_setting(rinse_set_r);
        PH_SET_SPIN:  spin_set_nxt  = bump_setting(spin_set_r);
        default:      wash_set_nxt  = wash_set_r;
      endcase
    end

    // Start, pause or resume
    if (in_ch.start_pause_press) begin
      unique case (phase_nxt)
        PH_IDLE: begin
          phase_nxt     = PH_WASH;
          sec_left_nxt  = phase_seconds(wash_set_nxt, sec_step_r);
          ms_left_nxt   = '0;
          since_ref_nxt = '0;
          wash_pos_nxt  = '0;
        end
        PH_WASH, PH_RINSE, PH_SPIN: begin
          saved_phase_nxt = phase_nxt;
          phase_nxt       = PH_PAUSE;
        end
        PH_PAUSE: phase_nxt = saved_phase_r;
        default:  phase_nxt = phase_nxt;
      endcase
    end

    // Cancel only from pause
    if (in_ch.cancel_press && phase_nxt == PH_PAUSE) begin
      phase_nxt    = PH_IDLE;
      sec_left_nxt = '0;
      ms_left_nxt  = '0;
      fwd_nxt      = 1'b0;
      rev_nxt      = 1'b0;
    end

    // Count the remaining time down one millisecond per tick
    running = (phase_nxt == PH_WASH) || (phase_nxt == PH_RINSE) || (phase_nxt == PH_SPIN);
    if (in_ch.tick && running && (sec_left_nxt != '0 || ms_left_nxt != '0)) begin
      if (ms_left_nxt == '0) begin
        sec_left_nxt = sec_left_nxt - 7'd1;
        ms_left_nxt  = MILLIS_TOP;
      end else begin
        ms_left_nxt = ms_left_nxt - 10'd1;
      end
    end

    // Move on when a run phase has run out
    if (sec_left_nxt == '0 && ms_left_nxt == '0) begin
      unique case (phase_nxt)
        PH_WASH: begin
          phase_nxt    = PH_RINSE;
          sec_left_nxt = phase_seconds(rinse_set_nxt, sec_step_r);
        end
        PH_RINSE: begin
          phase_nxt    = PH_SPIN;
          sec_left_nxt = phase_seconds(spin_set_nxt, sec_step_r);
        end
        PH_SPIN: phase_nxt = PH_IDLE;
        default: phase_nxt = phase_nxt;
      endcase
    end

    // Motor duty and direction lines
    unique case (phase_nxt)
      PH_IDLE, PH_PAUSE: begin
        fwd_nxt = 1'b0;
        rev_nxt = 1'b0;
      end
      PH_WASH: begin
        duty_nxt = wash_duty_r;
        fwd_nxt  = (wash_pos_nxt < WASH_FWD_END);
        rev_nxt  = (wash_pos_nxt >= WASH_GAP1_END) && (wash_pos_nxt < WASH_REV_END);
      end
      PH_RINSE: begin
        duty_nxt = rinse_duty_r;
        if (since_ref_nxt >= RINSE_FLIP) begin
          since_ref_nxt = '0;
          wash_pos_nxt  = '0;
          rinse_dir_nxt = !rinse_dir_r;
          fwd_nxt       = rinse_dir_nxt;
          rev_nxt       = !rinse_dir_nxt;
        end
      end
      PH_SPIN: begin
        duty_nxt = spin_duty_r;
        fwd_nxt  = 1'b1;
        rev_nxt  = 1'b0;
      end
      default: begin
        fwd_nxt = fwd_nxt;
      end
    endcase

    // Status LEDs
    unique case (phase_nxt)
      PH_WASH:      led_nxt = LED_WASH;
      PH_RINSE:     led_nxt = LED_RINSE;
      PH_SPIN:      led_nxt = LED_SPIN;
      PH_SET_WASH:  led_nxt = LED_SET_WASH;
      PH_SET_RINSE: led_nxt = LED_SET_RINSE;
      PH_SET_SPIN:  led_nxt = LED_SET_SPIN;
      PH_PAUSE:     led_nxt = LED_PAUSE;
      PH_IDLE:      led_nxt = LED_OFF;
    endcase

    // Display: setting value in the menu, remaining time otherwise
    unique case (phase_nxt)
      PH_SET_WASH: begin
        secs_nxt = {3'd0, wash_set_nxt};
        ms_nxt   = '0;
      end
      PH_SET_RINSE: begin
        secs_nxt = {3'd0, rinse_set_nxt};
        ms_nxt   = '0;
      end
      PH_SET_SPIN: begin
        secs_nxt = {3'd0, spin_set_nxt};
        ms_nxt   = '0;
      end
      default: begin
        secs_nxt = sec_left_nxt;
        ms_nxt   = ms_left_nxt;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wash_duty_r  <= WASH_DUTY_RST;
      rinse_duty_r <= RINSE_DUTY_RST;
      spin_duty_r  <= SPIN_DUTY_RST;
      sec_step_r   <= SEC_STEP_RST;
    end else if (cfg_fire) begin
      unique case (cfg_ch.index)
        REG_WASH_DUTY:  wash_duty_r  <= cfg_ch.data;
        REG_RINSE_DUTY: rinse_duty_r <= cfg_ch.data;
        REG_SPIN_DUTY:  spin_duty_r  <= cfg_ch.data;
        REG_SEC_STEP:   sec_step_r   <= cfg_ch.data[3:0];
        default:        sec_step_r   <= sec_step_r;
      endcase
    end
  end

  // Sequencer state: advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      saved_phase_r <= PH_IDLE;
      wash_set_r    <= 4'd1;
      rinse_set_r   <= 4'd1;
      spin_set_r    <= 4'd1;
      sec_left_r    <= '0;
      ms_left_r     <= '0;
      since_ref_r   <= '0;
      wash_pos_r    <= '0;
      rinse_dir_r   <= 1'b0;
      fwd_r         <= 1'b0;
      rev_r         <= 1'b0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      saved_phase_r <= saved_phase_nxt;
      wash_set_r    <= wash_set_nxt;
      rinse_set_r   <= rinse_set_nxt;
      spin_set_r    <= spin_set_nxt;
      sec_left_r    <= sec_left_nxt;
      ms_left_r     <= ms_left_nxt;
      since_ref_r   <= since_ref_nxt;
      wash_pos_r    <= wash_pos_nxt;
      rinse_dir_r   <= rinse_dir_nxt;
      fwd_r         <= fwd_nxt;
      rev_r         <= rev_nxt;
    end
  end

  // Result register: hold until taken, load on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      duty_r <= duty_nxt;
      led_r  <= led_nxt;
      secs_r <= secs_nxt;
      ms_r   <= ms_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.phase_code    = phase_r;
  assign out_ch.motor_duty    = duty_r;
  assign out_ch.drive_forward = fwd_r;
  assign out_ch.drive_reverse = rev_r;
  assign out_ch.led_pattern   = led_r;
  assign out_ch.seconds_shown = secs_r;
  assign out_ch.millis_shown  = ms_r;

  // Checks
  `WCS_ASSERT_NEXT(a_beat_gives_result, clk, rst_n, in_fire, out_valid_r)
  `WCS_ASSERT_IMPL(a_lines_exclusive, clk, rst_n, 1'b1, !(fwd_r && rev_r))
  `WCS_ASSERT_IMPL(a_millis_range, clk, rst_n, 1'b1, ms_left_r <= MILLIS_TOP)
  `WCS_ASSERT_IMPL(a_duty_only_running, clk, rst_n, out_valid_r && duty_r != 8'd0,
                   phase_r == PH_WASH || phase_r == PH_RINSE || phase_r == PH_SPIN)

endmodule

FILE: dv/wcs_result_checker.sv
// Result checker of the wash-cycle sequencer: predicts every control pass and compares beats.
// Depends on wcs_pkg and the input, result and configuration channel interfaces.
`timescale 1ns / 1ps

module wcs_result_checker
  import wcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  wcs_in_if           in_mon,
  wcs_out_if          out_mon,
  wcs_cfg_if          cfg_mon,
  output int unsigned fail_count,
  output int unsigned views_pending,
  output int unsigned views_checked
);

  // Motor direction lines
  localparam logic [1:0] LINES_OFF = 2'b00;
  localparam logic [1:0] LINES_FWD = 2'b01;
  localparam logic [1:0] LINES_REV = 2'b10;

  // Agitation timing in milliseconds
  localparam logic [31:0] AGITATE_PERIOD  = 32'd8000;
  localparam logic [31:0] AGITATE_FWD_END = 32'd3000;
  localparam logic [31:0] AGITATE_GAP_END = 32'd4000;
  localparam logic [31:0] AGITATE_REV_END = 32'd7000;
  localparam logic [31:0] RINSE_FLIP_MS   = 32'd2000;
  localparam logic [9:0]  MS_WRAP         = 10'd999;
  localparam int unsigned SECS_CAP        = 99;
  localparam logic [3:0]  UNITS_TOP       = 4'd9;

  // Status lamps
  localparam logic [7:0] LAMP_OFF       = 8'h00;
  localparam logic [7:0] LAMP_WASH      = 8'h01;
  localparam logic [7:0] LAMP_RINSE     = 8'h02;
  localparam logic [7:0] LAMP_SPIN      = 8'h04;
  localparam logic [7:0] LAMP_SET_WASH  = 8'h08;
  localparam logic [7:0] LAMP_SET_RINSE = 8'h10;
  localparam logic [7:0] LAMP_SET_SPIN  = 8'h20;
  localparam logic [7:0] LAMP_PAUSE     = 8'h80;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] duty;
    logic       fwd;
    logic       rev;
    logic [7:0] led;
    logic [6:0] secs;
    logic [9:0] ms;
  } wash_view_t;

  // Predicted sequencer state
  phase_t      cur_phase;
  phase_t      held_phase;
  logic [3:0]  wash_units;
  logic [3:0]  rinse_units;
  logic [3:0]  spin_units;
  logic [6:0]  secs_remain;
  logic [9:0]  ms_remain;
  logic [31:0] tick_count;
  logic        rinse_dir;
  logic [1:0]  motor_lines;

  // Register copies
  logic [7:0]  wash_pwm;
  logic [7:0]  rinse_pwm;
  logic [7:0]  spin_pwm;
  logic [3:0]  step_secs;

  wash_view_t  pending_views[$];
  wash_view_t  got_view;
  wash_view_t  want_view;

  task automatic reset_model();
    cur_phase   = PH_IDLE;
    held_phase  = PH_IDLE;
    wash_units  = 4'd1;
    rinse_units = 4'd1;
    spin_units  = 4'd1;
    secs_remain = '0;
    ms_remain   = '0;
    tick_count  = '0;
    rinse_dir   = 1'b0;
    motor_lines = LINES_OFF;
    wash_pwm    = 8'd120;
    rinse_pwm   = 8'd180;
    spin_pwm    = 8'd255;
    step_secs   = 4'd10;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_WASH_DUTY:  wash_pwm  = value;
      REG_RINSE_DUTY: rinse_pwm = value;
      REG_SPIN_DUTY:  spin_pwm  = value;
      REG_SEC_STEP:   step_secs = value[3:0];
      default: ;
    endcase
  endtask

  // Phase length in seconds, capped at the display limit
  function automatic logic [6:0] phase_len(input logic [3:0] units);
    int unsigned product;
    product = units;
    product = product * step_secs;
    if (product > SECS_CAP) product = SECS_CAP;
    return product[6:0];
  endfunction

  function automatic logic [3:0] next_units(input logic [3:0] v);
    return (v >= UNITS_TOP) ? 4'd1 : v + 4'd1;
  endfunction

  // Apply one control pass to the predicted state and return what the display shows
  function automatic wash_view_t compute_view(input logic tick, input logic mode,
                                              input logic adj, input logic sp,
                                              input logic cancel);
    wash_view_t  v;
    logic [31:0] slot;
    logic        running;

    if (tick) tick_count = tick_count + 32'd1;

    // Menu walk
    if (mode) begin
      case (cur_phase)
        PH_IDLE:      cur_phase = PH_SET_WASH;
        PH_SET_WASH:  cur_phase = PH_SET_RINSE;
        PH_SET_RINSE: cur_phase = PH_SET_SPIN;
        PH_SET_SPIN:  cur_phase = PH_IDLE;
        default: ;
      endcase
    end

    // Raise the setting on show
    if (adj) begin
      case (cur_phase)
        PH_SET_WASH:  wash_units  = next_units(wash_units);
        PH_SET_RINSE: rinse_units = next_units(rinse_units);
        PH_SET_SPIN:  spin_units  = next_units(spin_units);
        default: ;
      endcase
    end

    // Start, pause or resume
    if (sp) begin
      if (cur_phase == PH_IDLE) begin
        cur_phase   = PH_WASH;
        secs_remain = phase_len(wash_units);
        ms_remain   = '0;
        tick_count  = '0;
      end else if (cur_phase == PH_WASH || cur_phase == PH_RINSE || cur_phase == PH_SPIN) begin
        held_phase = cur_phase;
        cur_phase  = PH_PAUSE;
      end else if (cur_phase == PH_PAUSE) begin
        cur_phase = held_phase;
      end
    end

    // Abort only out of pause
    if (cancel && cur_phase == PH_PAUSE) begin
      cur_phase   = PH_IDLE;
      secs_remain = '0;
      ms_remain   = '0;
      motor_lines = LINES_OFF;
    end

    // Count down one millisecond
    running = (cur_phase == PH_WASH) || (cur_phase == PH_RINSE) || (cur_phase == PH_SPIN);
    if (tick && running && (secs_remain != 0 || ms_remain != 0)) begin
      if (ms_remain == 0) begin
        secs_remain = secs_remain - 7'd1;
        ms_remain   = MS_WRAP;
      end else begin
        ms_remain = ms_remain - 10'd1;
      end
    end

    // Advance at most one phase when time runs out
    if (secs_remain == 0 && ms_remain == 0) begin
      case (cur_phase)
        PH_WASH: begin
          cur_phase   = PH_RINSE;
          secs_remain = phase_len(rinse_units);
          ms_remain   = '0;
        end
        PH_RINSE: begin
          cur_phase   = PH_SPIN;
          secs_remain = phase_len(spin_units);
          ms_remain   = '0;
        end
        PH_SPIN: cur_phase = PH_IDLE;
        default: ;
      endcase
    end

    // Motor duty and direction
    v.duty = 8'd0;
    case (cur_phase)
      PH_IDLE, PH_PAUSE: motor_lines = LINES_OFF;
      PH_WASH: begin
        v.duty = wash_pwm;
        slot   = tick_count % AGITATE_PERIOD;
        if (slot < AGITATE_FWD_END)      motor_lines = LINES_FWD;
        else if (slot < AGITATE_GAP_END) motor_lines = LINES_OFF;
        else if (slot < AGITATE_REV_END) motor_lines = LINES_REV;
        else                             motor_lines = LINES_OFF;
      end
      PH_RINSE: begin
        v.duty = rinse_pwm;
        if (tick_count >= RINSE_FLIP_MS) begin
          tick_count  = '0;
          rinse_dir   = ~rinse_dir;
          motor_lines = rinse_dir ? LINES_FWD : LINES_REV;
        end
      end
      PH_SPIN: begin
        v.duty      = spin_pwm;
        motor_lines = LINES_FWD;
      end
      default: ;
    endcase

    case (cur_phase)
      PH_WASH:      v.led = LAMP_WASH;
      PH_RINSE:     v.led = LAMP_RINSE;
      PH_SPIN:      v.led = LAMP_SPIN;
      PH_SET_WASH:  v.led = LAMP_SET_WASH;
      PH_SET_RINSE: v.led = LAMP_SET_RINSE;
      PH_SET_SPIN:  v.led = LAMP_SET_SPIN;
      PH_PAUSE:     v.led = LAMP_PAUSE;
      default:      v.led = LAMP_OFF;
    endcase

    // Set phases show the setting, the rest show the time left
    case (cur_phase)
      PH_SET_WASH: begin
        v.secs = {3'd0, wash_units};
        v.ms   = '0;
      end
      PH_SET_RINSE: begin
        v.secs = {3'd0, rinse_units};
        v.ms   = '0;
      end
      PH_SET_SPIN: begin
        v.secs = {3'd0, spin_units};
        v.ms   = '0;
      end
      default: begin
        v.secs = secs_remain;
        v.ms   = ms_remain;
      end
    endcase

    v.phase = cur_phase;
    v.fwd   = motor_lines[0];
    v.rev   = motor_lines[1];
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fail_count++;
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Watch the three channels at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      pending_views.delete();
      fail_count    = 0;
      views_checked = 0;
    end else begin
      // Registers are to change only while nothing is in flight; the checker does not enforce it
      if (cfg_mon.valid && cfg_mon.ready) write_register(cfg_mon.index, cfg_mon.data);

      // Match a result beat against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got_view.phase = out_mon.phase_code;
        got_view.duty  = out_mon.motor_duty;
        got_view.fwd   = out_mon.drive_forward;
        got_view.rev   = out_mon.drive_reverse;
        got_view.led   = out_mon.led_pattern;
        got_view.secs  = out_mon.seconds_shown;
        got_view.ms    = out_mon.millis_shown;
        if (pending_views.size() == 0) begin
          report_mismatch("result beat with nothing expected", got_view.phase, 0);
        end else begin
          want_view = pending_views.pop_front();
          views_checked++;
          if (got_view.phase !== want_view.phase)
            report_mismatch("phase_code", got_view.phase, want_view.phase);
          if (got_view.duty !== want_view.duty)
            report_mismatch("motor_duty", got_view.duty, want_view.duty);
          if (got_view.fwd !== want_view.fwd)
            report_mismatch("drive_forward", got_view.fwd, want_view.fwd);
          if (got_view.rev !== want_view.rev)
            report_mismatch("drive_reverse", got_view.rev, want_view.rev);
          if (got_view.led !== want_view.led)
            report_mismatch("led_pattern", got_view.led, want_view.led);
          if (got_view.secs !== want_view.secs)
            report_mismatch("seconds_shown", got_view.secs, want_view.secs);
          if (got_view.ms !== want_view.ms)
            report_mismatch("millis_shown", got_view.ms, want_view.ms);
        end
      end

      // Predict the accepted control pass
      if (in_mon.valid && in_mon.ready)
        pending_views.push_back(compute_view(in_mon.tick, in_mon.mode_press,
                                             in_mon.adjust_press, in_mon.start_pause_press,
                                             in_mon.cancel_press));
    end
    views_pending = pending_views.size();
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top of the wash-cycle sequencer: clock, reset, stimulus and the verdict.
// Depends on wcs_pkg, the channel interfaces, wash_cycle_sequencer and wcs_result_checker.
`timescale 1ns / 1ps

module tb_top;
  import wcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 500_000;
  localparam int unsigned RANDOM_PASSES   = 140;
  localparam int unsigned LONG_RUN_PASSES = 200;

  logic        clk;
  logic        rst_n;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned passes_sent;
  int unsigned reg_writes;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned views_pending;
  int unsigned views_checked;

  wcs_in_if  in_ch();
  wcs_out_if out_ch();
  wcs_cfg_if cfg_ch();

  wash_cycle_sequencer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  wcs_result_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .fail_count    (fail_count),
    .views_pending (views_pending),
    .views_checked (views_checked)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Result side: stall at random at each falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic chance(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic set_idling(input int unsigned src, input int unsigned snk);
    src_idle_pct  = src;
    snk_stall_pct = snk;
  endtask

  // Drive one control pass and hold it until the beat is taken
  task automatic send_pass(input logic tick, input logic mode, input logic adj,
                           input logic sp, input logic cancel);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.tick              <= tick;
    in_ch.mode_press        <= mode;
    in_ch.adjust_press      <= adj;
    in_ch.start_pause_press <= sp;
    in_ch.cancel_press      <= cancel;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    passes_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted beat has come back
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    while (views_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // One user session: menu walk, run burst, pause and cancel; or plain button noise
  task automatic wash_episode();
    int unsigned n;
    int unsigned k;
    if ($urandom_range(0, 9) < 3) begin
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++)
        send_pass(chance(70), chance(30), chance(30), chance(30), chance(30));
    end else begin
      // walk the menu back round to idle, raising settings on the way
      for (k = 0; k < 4; k++) begin
        send_pass(chance(85), 1'b1, 1'b0, 1'b0, 1'b0);
        n = $urandom_range(0, 4);
        repeat (n) send_pass(chance(85), 1'b0, 1'b1, 1'b0, 1'b0);
      end
      send_pass(chance(85), 1'b0, 1'b0, 1'b1, 1'b0);
      n = $urandom_range(4, 60);
      for (k = 0; k < n; k++)
        send_pass(chance(90), 1'b0, 1'b0, chance(4), chance(8));
      send_pass(chance(85), 1'b0, 1'b0, 1'b1, 1'b1);
    end
  endtask

  task automatic random_phase(input int unsigned src, input int unsigned snk,
                              input logic [CFG_DATA_W-1:0] step_value);
    int unsigned first;
    settle_idle();
    write_reg(REG_WASH_DUTY, 8'($urandom_range(0, 255)));
    write_reg(REG_RINSE_DUTY, 8'($urandom_range(0, 255)));
    write_reg(REG_SPIN_DUTY, 8'($urandom_range(0, 255)));
    write_reg(REG_SEC_STEP, step_value);
    set_idling(src, snk);
    first = passes_sent;
    while (passes_sent - first < RANDOM_PASSES) wash_episode();
  endtask

  // Run a stretch of wash with ticks on nearly every pass and the odd pause
  task automatic long_run();
    int unsigned n;
    int unsigned hold_left;
    hold_left = 0;
    send_pass(1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    for (n = 0; n < LONG_RUN_PASSES; n++) begin
      if (hold_left != 0) begin
        hold_left--;
        send_pass(1'b1, 1'b0, 1'b0, hold_left == 0, 1'b0);
      end else if ($urandom_range(0, 1999) == 0) begin
        hold_left = $urandom_range(20, 300);
        send_pass(1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      end else if ($urandom_range(0, 299) == 0) begin
        send_pass(1'b1, 1'b1, 1'b1, 1'b0, chance(50));
      end else begin
        send_pass($urandom_range(0, 19) != 0, 1'b0, 1'b0, 1'b0, 1'b0);
      end
    end
  endtask

  initial begin
    rst_n                    = 1'b0;
    passes_sent              = 0;
    reg_writes               = 0;
    in_ch.valid              = 1'b0;
    in_ch.tick               = 1'b0;
    in_ch.mode_press         = 1'b0;
    in_ch.adjust_press       = 1'b0;
    in_ch.start_pause_press  = 1'b0;
    in_ch.cancel_press       = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = '0;
    cfg_ch.data              = '0;
    set_idling(0, 0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset registers: menu, wrap-free raise to nine, ignored presses, pause, resume and cancel
    send_pass(0, 0, 0, 0, 0);
    send_pass(1, 0, 1, 0, 1);
    send_pass(0, 1, 0, 0, 0);
    repeat (8) send_pass(1, 0, 1, 0, 0);
    send_pass(0, 1, 1, 0, 0);
    send_pass(1, 1, 0, 1, 1);
    send_pass(0, 0, 1, 0, 0);
    send_pass(0, 1, 1, 0, 0);
    send_pass(1, 0, 0, 1, 0);
    send_pass(1, 0, 0, 1, 1);
    send_pass(0, 0, 0, 1, 0);
    send_pass(1, 0, 0, 1, 0);
    send_pass(1, 0, 0, 0, 0);
    send_pass(0, 0, 0, 1, 0);
    send_pass(1, 1, 1, 0, 1);
    send_pass(0, 0, 0, 1, 0);
    send_pass(0, 0, 0, 0, 1);

    // Largest step: phase time saturates; unmapped indexes dropped; zero duties
    settle_idle();
    write_reg(REG_SEC_STEP, 8'hFF);
    write_reg(8'd4, 8'h55);
    write_reg(8'hFF, 8'hAA);
    write_reg(REG_WASH_DUTY, 8'd0);
    write_reg(REG_RINSE_DUTY, 8'd0);
    write_reg(REG_SPIN_DUTY, 8'd0);
    send_pass(0, 0, 0, 1, 0);
    send_pass(1, 0, 0, 0, 0);
    send_pass(1, 0, 0, 1, 1);

    // Zero step: every phase ends as soon as it starts; full duties
    settle_idle();
    write_reg(REG_SEC_STEP, 8'h10);
    write_reg(REG_WASH_DUTY, 8'd255);
    write_reg(REG_RINSE_DUTY, 8'd255);
    write_reg(REG_SPIN_DUTY, 8'd255);
    send_pass(1, 0, 0, 1, 0);
    send_pass(0, 0, 0, 0, 0);
    send_pass(1, 0, 0, 0, 0);
    send_pass(1, 0, 0, 0, 0);

    // One-second step: a stretch of ticking wash with light idling on both sides
    settle_idle();
    write_reg(REG_SEC_STEP, 8'd1);
    write_reg(REG_WASH_DUTY, 8'($urandom_range(1, 254)));
    write_reg(REG_RINSE_DUTY, 8'($urandom_range(1, 254)));
    write_reg(REG_SPIN_DUTY, 8'($urandom_range(1, 254)));
    set_idling(15, 15);
    long_run();

    // Random sessions, one idling mode each
    random_phase(0, 0, 8'd0);
    random_phase(59, 0, 8'd1);
    random_phase(0, 59, 8'($urandom_range(2, 15)));
    random_phase(15, 15, 8'($urandom_range(0, 255)));

    settle_idle();
    repeat (8) @(negedge clk);
    $display("Run covered %0d control passes, %0d checked result beats, %0d register writes:",
             passes_sent, views_checked, reg_writes);
    $display("corner passes, a ticking wash stretch and random sessions in four idling modes");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
